@@ hdl/aarm_pkg.sv @@
`default_nettype none
package aarm_pkg;

  localparam int FracBits    = 14;
  localparam int CordicSteps = 16;
  localparam int AngW        = 34;
  localparam int CsW         = 33;
  localparam int StagesPer   = 4;
  localparam int CordicStg   = CordicSteps / StagesPer;

  localparam logic signed [CsW-1:0] GainQ30 = 33'sd652032874;
  localparam logic signed [CsW-1:0] OneQ30  = 33'sd1073741824;

  typedef logic signed [15:0] s16_t;

  typedef struct packed {
    s16_t axis_x;
    s16_t axis_y;
    s16_t axis_z;
    s16_t angle;
  } aarm_req_t;

  typedef struct packed {
    s16_t m_r0c0;
    s16_t m_r0c1;
    s16_t m_r0c2;
    s16_t m_r1c0;
    s16_t m_r1c1;
    s16_t m_r1c2;
    s16_t m_r2c0;
    s16_t m_r2c1;
    s16_t m_r2c2;
  } aarm_rsp_t;

  function automatic logic signed [AngW-1:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage
`default_nettype wire

@@ hdl/aarm_if.sv @@
`default_nettype none
interface aarm_if #(parameter int W = 64) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/axis_angle_rotation_matrix_unit.sv @@
// axis-angle (rodrigues) rotation matrix unit
// in: request channel, data = {axis_x, axis_y, axis_z, angle}, each signed 16 bit
//   axis in Q2.14, angle as binary angle with 32768 = pi
// out: response channel, data = nine Q2.14 saturated entries, row 0 column 0 first
//   in the top bits
// pipeline: 1 reduction stage, 4 cordic stages of 4 iterations each, then
//   products, sums and rounding in 4 stages, 9 stages in all
// throughput: one request per cycle while the pipe is not stalled; every stage advances together
// the input ready is high whenever the output stage is empty or is being taken
// stall: when out.ready is low and the last stage is full, the whole pipe holds
//   and in.ready drops; nothing is lost or repeated
// reset: rst (synchronous) clears all stage valid bits; the pipe starts empty
`default_nettype none
module axis_angle_rotation_matrix_unit (
  input wire logic clk,
  input wire logic rst,
  aarm_if.sink     in,
  aarm_if.source   out
);
  import aarm_pkg::*;

  localparam int NStg = 1 + CordicStg + 4;
  localparam int PW = CsW + 32;
  localparam int AW = PW + 2;

  // sign codes of the sine term
  localparam logic [1:0] SignDiag  = 2'd0;
  localparam logic [1:0] SignPlus  = 2'd1;
  localparam logic [1:0] SignMinus = 2'd2;

  logic [NStg-1:0] vld;
  logic adv;

  assign adv      = !vld[NStg-1] || out.ready;
  assign in.ready = adv;

  aarm_req_t req;
  assign req = aarm_req_t'(in.data);

  s16_t ax [CordicStg+1];
  s16_t ay [CordicStg+1];
  s16_t az [CordicStg+1];
  logic flip [CordicStg+1];
  logic signed [CsW-1:0] cx [CordicStg+1];
  logic signed [CsW-1:0] cy [CordicStg+1];
  logic signed [AngW-1:0] cz [CordicStg+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NStg-2:0], in.valid};
    end
  end

  logic signed [AngW-1:0] z0;
  logic f0;
  always_comb begin
    z0 = AngW'(req.angle) <<< 16;
    f0 = 1'b0;
    if (req.angle > 16'sd16384) begin
      z0 = z0 - (AngW'(1) <<< 31);
      f0 = 1'b1;
    end else if (req.angle < -16'sd16384) begin
      z0 = z0 + (AngW'(1) <<< 31);
      f0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax[0] <= req.axis_x;
      ay[0] <= req.axis_y;
      az[0] <= req.axis_z;
      cx[0] <= GainQ30;
      cy[0] <= '0;
      cz[0] <= z0;
      flip[0] <= f0;
    end
  end

  for (genvar g = 0; g < CordicStg; g++) begin : g_cordic
    logic signed [CsW-1:0] xn, yn;
    logic signed [AngW-1:0] zn;
    always_comb begin
      logic signed [CsW-1:0] tx;
      xn = cx[g];
      yn = cy[g];
      zn = cz[g];
      for (int k = 0; k < StagesPer; k++) begin
        tx = xn;
        if (zn >= 0) begin
          xn = xn - (yn >>> (g*StagesPer+k));
          yn = yn + (tx >>> (g*StagesPer+k));
          zn = zn - atan_turn(g*StagesPer+k);
        end else begin
          xn = xn + (yn >>> (g*StagesPer+k));
          yn = yn - (tx >>> (g*StagesPer+k));
          zn = zn + atan_turn(g*StagesPer+k);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cx[g+1] <= xn;
        cy[g+1] <= yn;
        cz[g+1] <= zn;
        flip[g+1] <= flip[g];
        ax[g+1] <= ax[g];
        ay[g+1] <= ay[g];
        az[g+1] <= az[g];
      end
    end
  end

  localparam int CS = CordicStg;

  // stage A: final cos/sin and 1 - cos, axis pair products
  logic signed [CsW-1:0] c_a, s_a, ci_a;
  logic signed [31:0] pp_a [9];
  s16_t su_a [9];
  logic [1:0] sk_a [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      c_a  <= flip[CS] ? -cx[CS] : cx[CS];
      s_a  <= flip[CS] ? -cy[CS] : cy[CS];
      ci_a <= OneQ30 - (flip[CS] ? -cx[CS] : cx[CS]);
      pp_a[0] <= ax[CS]*ax[CS]; pp_a[1] <= ax[CS]*ay[CS]; pp_a[2] <= ax[CS]*az[CS];
      pp_a[3] <= ay[CS]*ax[CS]; pp_a[4] <= ay[CS]*ay[CS]; pp_a[5] <= ay[CS]*az[CS];
      pp_a[6] <= az[CS]*ax[CS]; pp_a[7] <= az[CS]*ay[CS]; pp_a[8] <= az[CS]*az[CS];
      su_a[0] <= '0;     su_a[1] <= az[CS]; su_a[2] <= ay[CS];
      su_a[3] <= az[CS]; su_a[4] <= '0;     su_a[5] <= ax[CS];
      su_a[6] <= ay[CS]; su_a[7] <= ax[CS]; su_a[8] <= '0;
    end
  end
  assign sk_a[0] = SignDiag;  assign sk_a[1] = SignMinus; assign sk_a[2] = SignPlus;
  assign sk_a[3] = SignPlus;  assign sk_a[4] = SignDiag;  assign sk_a[5] = SignMinus;
  assign sk_a[6] = SignMinus; assign sk_a[7] = SignPlus;  assign sk_a[8] = SignDiag;

  // stage B: ci*ab split into two 33x16 halves, sine product
  logic signed [PW-1:0] hi_b [9];
  logic signed [PW-1:0] lo_b [9];
  logic signed [PW-1:0] sp_b [9];
  logic signed [CsW-1:0] c_b;
  always_ff @(posedge clk) begin
    if (adv) begin
      c_b <= c_a;
      for (int e = 0; e < 9; e++) begin
        hi_b[e] <= PW'(ci_a * $signed(pp_a[e][31:16]));
        lo_b[e] <= PW'(ci_a * $signed({1'b0, pp_a[e][15:0]}));
        sp_b[e] <= PW'(s_a * su_a[e]);
      end
    end
  end

  // stage C: combine and round by FracBits
  logic signed [AW-1:0] acc_c [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 9; e++) begin
        logic signed [AW-1:0] prod, rnd, t;
        prod = (AW'(hi_b[e]) <<< 16) + AW'(lo_b[e]);
        rnd  = (prod + (AW'(1) <<< (FracBits-1))) >>> FracBits;
        t = rnd;
        if (sk_a[e] == SignDiag) t = t + (AW'(c_b) <<< FracBits);
        else if (sk_a[e] == SignPlus) t = t + AW'(sp_b[e]);
        else t = t - AW'(sp_b[e]);
        acc_c[e] <= t;
      end
    end
  end

  // stage D: round by 30 and saturate
  aarm_rsp_t rsp;
  s16_t res [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 9; e++) begin
        logic signed [AW-1:0] r;
        r = (acc_c[e] + (AW'(1) <<< 29)) >>> 30;
        if (r > AW'(32767)) res[e] <= 16'sh7FFF;
        else if (r < -AW'(32768)) res[e] <= 16'sh8000;
        else res[e] <= r[15:0];
      end
    end
  end

  assign rsp = '{res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8]};
  assign out.valid = vld[NStg-1];
  assign out.data  = rsp;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.data))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out.valid |-> in.ready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in.ready && !in.valid && !(|vld) |=> !out.valid)
    else $error("result invented");
`endif
endmodule
`default_nettype wire
